// ===== sv/hnuv_pkg.sv =====
// Package for the host and user name validator: transaction structs,
// configuration register indexes, reset values and character classes.
// No dependencies.
package hnuv_pkg;

  localparam logic [7:0] HostLimitReset  = 8'd255;
  localparam logic [7:0] UserLimitReset  = 8'd32;
  localparam logic [6:0] LabelLimitReset = 7'd63;

  localparam logic [7:0] CharPeriod = 8'h2E;  // '.'
  localparam logic [7:0] CharHyphen = 8'h2D;  // '-'

  typedef enum logic [1:0] {
    CFG_HOST_LIMIT  = 2'd0,
    CFG_USER_LIMIT  = 2'd1,
    CFG_LABEL_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_user_name;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    logic checked_user_name;
    logic name_ok;
    logic length_error;
    logic first_char_error;
    logic illegal_char_error;
    logic hyphen_end_error;
    logic label_error;
    logic digit_order_error;
    logic capital_with_digits_error;
  } out_item_t;

  typedef struct packed {
    logic length;
    logic first;
    logic illegal;
    logic hyphen;
    logic label;
    logic dig_order;
    logic caps;
  } err_t;

  typedef struct packed {
    logic [7:0] host_limit;
    logic [7:0] user_limit;
    logic [6:0] label_limit;
  } limits_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// ===== sv/hnuv_cfg.sv =====
// Configuration registers of the host and user name validator.
// Depends on hnuv_pkg.
module hnuv_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output logic              cfg_ready_o,
  output hnuv_pkg::limits_t limits_o
);
  import hnuv_pkg::*;

  limits_t limits_q, limits_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    limits_d = limits_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HOST_LIMIT:  limits_d.host_limit  = cfg_data_i;
        CFG_USER_LIMIT:  limits_d.user_limit  = cfg_data_i;
        CFG_LABEL_LIMIT: limits_d.label_limit = cfg_data_i[6:0];
        default:         limits_d = limits_q;  // drop writes to unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.host_limit  <= HostLimitReset;
      limits_q.user_limit  <= UserLimitReset;
      limits_q.label_limit <= LabelLimitReset;
    end else begin
      limits_q <= limits_d;
    end
  end

  assign limits_o = limits_q;

endmodule

// ===== sv/hnuv_core.sv =====
// Per-string check state and rule logic of the host and user name validator.
// Depends on hnuv_pkg.
module hnuv_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  hnuv_pkg::in_item_t  item_i,
  input  hnuv_pkg::limits_t   limits_i,
  output hnuv_pkg::out_item_t result_o
);
  import hnuv_pkg::*;

  logic [8:0] char_count_q, char_count_d;
  logic [7:0] label_count_q, label_count_d;
  logic       prev_period_q, prev_period_d;
  logic       prev_hyphen_q, prev_hyphen_d;
  logic       first_upper_q, first_upper_d;
  logic       digit_seen_q, digit_seen_d;
  err_t       err_q, err_d, err_new;

  logic [7:0] c;
  logic       first, upper, digit, alpha, alnum, period, hyphen;
  logic [7:0] label_inc;

  always_comb begin
    c      = item_i.char_code;
    first  = (char_count_q == '0);
    upper  = is_upper(c);
    digit  = is_digit(c);
    alpha  = upper | is_lower(c);
    alnum  = alpha | digit;
    period = (c == CharPeriod);
    hyphen = (c == CharHyphen);

    char_count_d  = (char_count_q == '1) ? char_count_q : char_count_q + 9'd1;
    label_inc     = (label_count_q == '1) ? label_count_q : label_count_q + 8'd1;
    label_count_d = label_count_q;
    err_new       = '0;

    if (item_i.is_user_name) begin
      err_new.length    = char_count_d > {1'b0, limits_i.user_limit};
      err_new.first     = first & ~alpha;
      err_new.illegal   = ~alnum;
      err_new.caps      = digit & (first_upper_q | (first & upper));
      err_new.dig_order = alpha & digit_seen_q;
    end else begin
      err_new.length  = char_count_d > {1'b0, limits_i.host_limit};
      err_new.first   = first & ~alnum;
      err_new.illegal = ~first & ~alnum & ~period & ~hyphen;
      err_new.hyphen  = (period & prev_hyphen_q) | (item_i.final_char & hyphen);
      if (period) begin
        label_count_d = '0;
        err_new.label = prev_period_q & ~alnum;
      end else begin
        label_count_d = label_inc;
        err_new.label = (prev_period_q & ~alnum) | (label_inc > {1'b0, limits_i.label_limit});
      end
    end

    err_d         = err_q | err_new;
    first_upper_d = first ? upper : first_upper_q;
    digit_seen_d  = digit_seen_q | digit;
    prev_period_d = period & ~first;
    prev_hyphen_d = hyphen;

    result_o.checked_user_name         = item_i.is_user_name;
    result_o.name_ok                   = (err_d == '0);
    result_o.length_error              = err_d.length;
    result_o.first_char_error          = err_d.first;
    result_o.illegal_char_error        = err_d.illegal;
    result_o.hyphen_end_error          = err_d.hyphen;
    result_o.label_error               = err_d.label;
    result_o.digit_order_error         = err_d.dig_order;
    result_o.capital_with_digits_error = err_d.caps;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q  <= '0;
      label_count_q <= '0;
      prev_period_q <= 1'b0;
      prev_hyphen_q <= 1'b0;
      first_upper_q <= 1'b0;
      digit_seen_q  <= 1'b0;
      err_q         <= '0;
    end else if (fire_i) begin
      if (item_i.final_char) begin
        // verdict given: start the next string from scratch
        char_count_q  <= '0;
        label_count_q <= '0;
        prev_period_q <= 1'b0;
        prev_hyphen_q <= 1'b0;
        first_upper_q <= 1'b0;
        digit_seen_q  <= 1'b0;
        err_q         <= '0;
      end else begin
        char_count_q  <= char_count_d;
        label_count_q <= label_count_d;
        prev_period_q <= prev_period_d;
        prev_hyphen_q <= prev_hyphen_d;
        first_upper_q <= first_upper_d;
        digit_seen_q  <= digit_seen_d;
        err_q         <= err_d;
      end
    end
  end

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.final_char |=> char_count_q == '0 && err_q == '0)
    else $error("string state not cleared after final character");

  a_count_moves_only_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(char_count_q) && $stable(err_q))
    else $error("string state changed without a character");

endmodule

// ===== sv/host_and_user_name_validator.sv =====
// Top level of the host and user name validator: input register, check core,
// result register and configuration port. Depends on hnuv_pkg, hnuv_cfg, hnuv_core.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | in_data_i  (hnuv_pkg::in_item_t)
//  out     | source    | out_valid_o / out_stall_i | out_data_o (hnuv_pkg::out_item_t)
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One character per cycle sustained, unless a final character waits for room in the
// result register. A character is held in the input register; the check core updates
// the string state as it leaves, and a final character's verdict lands in the result
// register as the final character leaves the input register.
// Reset restores the three limit registers to 255, 32 and 63 and clears all
// string state; no clearing pass is needed.
// While a verdict waits under out_stall_i, non-final characters keep flowing;
// only a second final character holds in the input register until the result
// register frees.
module host_and_user_name_validator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hnuv_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hnuv_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import hnuv_pkg::*;

  limits_t   limits;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, result;
  logic      out_valid_q;
  logic      out_free;   // result register can take a verdict this cycle
  logic      fire;       // held character is checked and leaves the input register

  hnuv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .limits_o    (limits)
  );

  hnuv_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .limits_i (limits),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  // non-final characters never wait; a final one waits for room in the result register
  assign fire       = in_valid_q && (!in_q.final_char || out_free);
  assign in_stall_o = in_valid_q && !fire;

  // Input register: load a new transaction whenever the held one leaves or none is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Result register: advance on a verdict, drop valid once the transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && in_q.final_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && in_q.final_char) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_verdict_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("waiting verdict lost or changed");

  a_final_held_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_q.final_char && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("final character checked while result register full");

  a_ok_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.name_ok == !(out_q.length_error || out_q.first_char_error ||
      out_q.illegal_char_error || out_q.hyphen_end_error || out_q.label_error ||
      out_q.digit_order_error || out_q.capital_with_digits_error))
    else $error("name_ok disagrees with error flags");

  a_plain_char_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_q.final_char |-> !in_stall_o)
    else $error("non-final character stalled");

endmodule
